// ----- rtl/core/midi_rpn_nrpn_detector_core_defines.svh -----
// Assertion macros used by the RPN/NRPN detector top level.
`ifndef MIDI_RPN_NRPN_DETECTOR_CORE_DEFINES_SVH
`define MIDI_RPN_NRPN_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MRND_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MRND_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/mrnd_pkg.sv -----
// Types, controller codes and constants of the RPN/NRPN detector.
package mrnd_pkg;

   localparam int NUM_CHANNELS = 16;
   localparam int CHAN_IDX_W   = $clog2(NUM_CHANNELS);

   localparam logic [6:0] CC_NRPN_LSB = 7'h62;
   localparam logic [6:0] CC_NRPN_MSB = 7'h63;
   localparam logic [6:0] CC_RPN_LSB  = 7'h64;
   localparam logic [6:0] CC_RPN_MSB  = 7'h65;
   localparam logic [6:0] CC_DATA_MSB = 7'h06;
   localparam logic [6:0] CC_DATA_LSB = 7'h26;

   // A stored byte: seven data bits and a mark that says it holds a value.
   typedef struct packed {
      logic       set;
      logic [6:0] value;
   } byte_type;

   typedef struct packed {
      byte_type param_msb;
      byte_type param_lsb;
      byte_type data_msb;
      byte_type data_lsb;
      logic     nrpn;
   } entry_type;

   localparam byte_type  BYTE_UNSET  = '{set: 1'b0, value: 7'h7f};
   localparam entry_type RESET_ENTRY = '{
      param_msb: BYTE_UNSET, param_lsb: BYTE_UNSET,
      data_msb: BYTE_UNSET, data_lsb: BYTE_UNSET, nrpn: 1'b0};

   typedef struct packed {
      logic        emit;
      logic [13:0] parameter_number;
      logic        is_nrpn;
      logic [13:0] param_value;
      logic        both_bytes;
   } result_type;

endpackage

// ----- rtl/core/mrnd_update.sv -----
// Per-channel entry update and message completion for one control change.
module mrnd_update (
   input  mrnd_pkg::entry_type  cur,
   input  logic [6:0]           controller_number,
   input  logic [6:0]           controller_value,
   output mrnd_pkg::entry_type  nxt,
   output logic                 wr,
   output mrnd_pkg::result_type res
);
   import mrnd_pkg::*;

   byte_type new_byte;
   logic     data_cc;
   logic     params_set;

   assign new_byte   = '{set: 1'b1, value: controller_value};
   assign params_set = nxt.param_msb.set & nxt.param_lsb.set;

   always_comb begin
      nxt     = cur;
      wr      = 1'b1;
      data_cc = 1'b0;
      unique case (controller_number)
         CC_NRPN_LSB, CC_RPN_LSB: begin
            nxt.param_lsb = new_byte;
            nxt.data_msb  = BYTE_UNSET;
            nxt.data_lsb  = BYTE_UNSET;
            nxt.nrpn      = (controller_number == CC_NRPN_LSB);
         end
         CC_NRPN_MSB, CC_RPN_MSB: begin
            nxt.param_msb = new_byte;
            nxt.data_msb  = BYTE_UNSET;
            nxt.data_lsb  = BYTE_UNSET;
            nxt.nrpn      = (controller_number == CC_NRPN_MSB);
         end
         CC_DATA_MSB: begin
            nxt.data_msb = new_byte;
            nxt.data_lsb = BYTE_UNSET;
            data_cc      = 1'b1;
         end
         CC_DATA_LSB: begin
            nxt.data_lsb = new_byte;
            data_cc      = 1'b1;
         end
         default: begin
            wr = 1'b0;
         end
      endcase
   end

   always_comb begin
      res.emit             = data_cc & params_set & nxt.data_msb.set;
      res.parameter_number = {nxt.param_msb.value, nxt.param_lsb.value};
      res.is_nrpn          = nxt.nrpn;
      res.both_bytes       = nxt.data_lsb.set;
      res.param_value      = {nxt.data_msb.value,
                              nxt.data_lsb.set ? nxt.data_lsb.value : 7'd0};
   end

endmodule

// ----- rtl/core/midi_rpn_nrpn_detector_core.sv -----
// Top level of the MIDI RPN/NRPN detector: channel state memory and stream ports.
//
// Usage
//   req_*  : one MIDI control change per request (channel 1-16, controller, value).
//   rsp_*  : one completed RPN/NRPN message, sent after a data entry controller
//            (0x06 or 0x26) when both parameter bytes and the data MSB are known.
//   Requests on channel 0 or above 16 and other controllers change nothing and
//   produce no response.
// Timing
//   A request accepted at an edge reads its channel entry from the state memory
//   at that edge; the entry is modified and written back when the modify stage
//   advances, where the response (if any) is loaded into the output register
//   that drives rsp_tvalid. One request per cycle is sustained while the output
//   is not stalled, also when back-to-back requests hit one channel: the last
//   write is forwarded to the read-modify-write stage.
// Reset and stall
//   Reset clears per-channel live bits; an entry not yet written reads as all
//   bytes unset with the NRPN flag low. No clearing pass is needed.
//   While a response waits and rsp_tready is low, req_tready drops and the
//   pipeline holds; otherwise a new request is taken as the response leaves.
module midi_rpn_nrpn_detector_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [4:0] midi_channel, [11:5] controller_number, [18:12] controller_value
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [4:0] out_channel, [18:5] parameter_number, [32:19] param_value, [33] both_bytes
   output logic [39:0] rsp_tdata,
   // [0] is_nrpn
   output logic        rsp_tuser
);
   import mrnd_pkg::*;

   `include "midi_rpn_nrpn_detector_core_defines.svh"

   logic [4:0]            req_channel;
   logic [6:0]            req_number;
   logic [6:0]            req_value;
   logic                  req_in_range;
   logic [CHAN_IDX_W-1:0] req_idx;
   logic                  advance;
   logic                  accept;

   // memory and live bits
   entry_type             mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] live_ff;
   entry_type             rd_entry_ff;
   logic                  rd_live_ff;

   // read-modify-write stage
   logic                  s1_valid_ff;
   logic [CHAN_IDX_W-1:0] s1_idx_ff;
   logic [4:0]            s1_channel_ff;
   logic [6:0]            s1_number_ff;
   logic [6:0]            s1_value_ff;

   // last write, forwarded to the next read of the same channel
   logic                  fwd_valid_ff;
   logic [CHAN_IDX_W-1:0] fwd_idx_ff;
   entry_type             fwd_entry_ff;
   logic                  fwd_hit;

   entry_type             cur_entry;
   entry_type             nxt_entry;
   logic                  upd_wr;
   logic                  wr_en;
   result_type            upd_res;

   // output register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [4:0]            rsp_channel_ff;
   result_type            rsp_res_ff;

   assign req_channel  = req_tdata[4:0];
   assign req_number   = req_tdata[11:5];
   assign req_value    = req_tdata[18:12];
   assign req_in_range = (req_channel != 5'd0) &&
                         ({27'd0, req_channel} <= NUM_CHANNELS);
   assign req_idx      = CHAN_IDX_W'(req_channel - 5'd1);

   // Pipeline moves whenever the output register is free or being drained.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   always_ff @(posedge clock) begin
      if (advance) begin
         rd_entry_ff <= mem[req_idx];
         rd_live_ff  <= live_ff[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept && req_in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_idx_ff     <= req_idx;
         s1_channel_ff <= req_channel;
         s1_number_ff  <= req_number;
         s1_value_ff   <= req_value;
      end
   end

   assign fwd_hit = fwd_valid_ff && (fwd_idx_ff == s1_idx_ff);

   always_comb begin
      priority if (fwd_hit) begin
         cur_entry = fwd_entry_ff;
      end else if (rd_live_ff) begin
         cur_entry = rd_entry_ff;
      end else begin
         cur_entry = RESET_ENTRY;
      end
   end

   mrnd_update u_update (
      .cur               (cur_entry),
      .controller_number (s1_number_ff),
      .controller_value  (s1_value_ff),
      .nxt               (nxt_entry),
      .wr                (upd_wr),
      .res               (upd_res)
   );

   assign wr_en = advance && s1_valid_ff && upd_wr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[s1_idx_ff] <= nxt_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff      <= '0;
         fwd_valid_ff <= 1'b0;
      end else if (wr_en) begin
         live_ff[s1_idx_ff] <= 1'b1;
         fwd_valid_ff       <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_idx_ff   <= s1_idx_ff;
         fwd_entry_ff <= nxt_entry;
      end
   end

   assign rsp_valid_in = s1_valid_ff && upd_res.emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_channel_ff <= s1_channel_ff;
         rsp_res_ff     <= upd_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_res_ff.is_nrpn;
   assign rsp_tdata  = {6'd0, rsp_res_ff.both_bytes, rsp_res_ff.param_value,
                        rsp_res_ff.parameter_number, rsp_channel_ff};

   `MRND_ASSERT_NOW(a_ready_only_on_stall, !req_tready, rsp_tvalid && !rsp_tready,
      "request side stalled without a blocked response")
   `MRND_ASSERT_NOW(a_write_needs_item, wr_en, s1_valid_ff && advance,
      "state write without an item in the modify stage")
   `MRND_ASSERT_NEXT(a_bad_channel_dropped, accept && !req_in_range, !s1_valid_ff,
      "out-of-range channel entered the modify stage")
   `MRND_ASSERT_NOW(a_rsp_channel_valid, rsp_tvalid,
      (rsp_tdata[4:0] != 5'd0) && rsp_tdata[12 + 20] == rsp_res_ff.param_value[13],
      "response channel zero or payload mispacked")
   `MRND_ASSERT_NEXT(a_write_sets_live, wr_en, live_ff[$past(s1_idx_ff)] && fwd_valid_ff,
      "written channel not marked live")

endmodule
